[hdl/esgf_pkg.sv]
package esgf_pkg;

  localparam int MAX_EXTENTS = 16;
  localparam int SECTOR_W = 32;
  localparam int GAP_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd1024;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SECTORS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP = 1'd1;

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_FINISH = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [SECTOR_W-1:0] start;
    logic [SECTOR_W-1:0] size;
  } extent_t;

  typedef struct packed {
    logic                load;
    logic                shift;
    logic [SECTOR_W-1:0] start;
    logic [SECTOR_W-1:0] size;
  } cell_ctrl_t;

endpackage

[hdl/esgf_in_if.sv]
interface esgf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [esgf_pkg::SECTOR_W-1:0] entry_start;
  logic [esgf_pkg::SECTOR_W-1:0] entry_size;
  logic                          is_filesystem;

  modport source(output valid, action, entry_start, entry_size, is_filesystem, input ready);
  modport sink(input valid, action, entry_start, entry_size, is_filesystem, output ready);
endinterface

[hdl/esgf_out_if.sv]
interface esgf_out_if;
  logic                          valid;
  logic                          ready;
  logic [esgf_pkg::SECTOR_W-1:0] region_start;
  logic [esgf_pkg::SECTOR_W-1:0] region_size;
  logic                          region_free;
  logic                          last_region;

  modport source(output valid, region_start, region_size, region_free, last_region,
                 input ready);
  modport sink(input valid, region_start, region_size, region_free, last_region,
               output ready);
endinterface

[hdl/extent_sort_and_gap_finder.sv]
// Extents are kept in a row of sorting cells ordered by start sector, and
// the block accepts one insert item in every cycle while idle. A
// finish item starts an emission run that drains the row through the head
// cell and a single output register: one region leaves per cycle when the
// output is taken. A run emits every extent and free gap; with an empty
// store whose trailing check fails it emits nothing. No input item is
// accepted during a run. Up to 16 extents are kept; further inserts are
// dropped. Register 0 is total_sectors, register 1 is min_gap.
module extent_sort_and_gap_finder (
  input  logic                            clk,
  input  logic                            rst,
  esgf_in_if.sink                         items,
  esgf_out_if.source                      regions,
  input  logic                            cfg_we,
  input  logic [esgf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esgf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int N = esgf_pkg::MAX_EXTENTS;
  localparam int SW = esgf_pkg::SECTOR_W;

  typedef enum logic {IDLE, EMIT} state_t;

  state_t                       state;
  logic [SW-1:0]                total_sectors;
  logic [esgf_pkg::GAP_W-1:0]   min_gap;
  logic [SW:0]                  prev_end;
  logic                         gap_done;

  esgf_pkg::cell_ctrl_t         ctrl;
  esgf_pkg::extent_t            cells [N];
  logic                         greater [N];

  logic                         fire;
  logic                         slot_free;
  logic                         emit_gap;
  logic                         emit_now;
  logic                         trail_pass;
  logic                         head_trail_pass;
  logic [SW:0]                  head_end;

  assign items.ready = (state == IDLE);
  assign fire = items.valid && items.ready;
  assign slot_free = !regions.valid || regions.ready;

  assign head_end = {1'b0, cells[0].start} + {1'b0, cells[0].size};
  assign emit_gap = !gap_done &&
                    (({1'b0, prev_end} + (SW+2)'(min_gap)) < {2'b00, cells[0].start});
  assign trail_pass = ({1'b0, prev_end} + (SW+2)'(min_gap)) < {2'b00, total_sectors};
  assign head_trail_pass = ({1'b0, head_end} + (SW+2)'(min_gap)) <
                           {2'b00, total_sectors};
  assign emit_now = (state == EMIT) && slot_free && (cells[0].valid || trail_pass);

  always_comb begin
    ctrl.load  = fire && (items.action == esgf_pkg::ACTION_INSERT) &&
                 items.is_filesystem && !cells[N-1].valid;
    ctrl.shift = (state == EMIT) && slot_free && cells[0].valid && !emit_gap;
    ctrl.start = items.entry_start;
    ctrl.size  = items.entry_size;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    esgf_pkg::extent_t left_d;
    esgf_pkg::extent_t right_d;
    logic              left_g;
    if (i == 0) begin : g_head
      assign left_d = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_d = cells[i-1];
      assign left_g = greater[i-1];
    end
    if (i == N-1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid
      assign right_d = cells[i+1];
    end
    esgf_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .left         (left_d),
      .left_greater (left_g),
      .right        (right_d),
      .held         (cells[i]),
      .greater      (greater[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_sectors <= '0;
      min_gap       <= esgf_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esgf_pkg::CFG_TOTAL_SECTORS: total_sectors <= cfg_data;
        esgf_pkg::CFG_MIN_GAP:       min_gap <= cfg_data[esgf_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      regions.valid  <= 1'b0;
      prev_end       <= '0;
      gap_done       <= 1'b0;
    end else begin
      if (emit_now) begin
        regions.valid <= 1'b1;
      end else if (regions.valid && regions.ready) begin
        regions.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (fire && (items.action == esgf_pkg::ACTION_FINISH)) begin
            state    <= EMIT;
            prev_end <= '0;
            gap_done <= 1'b0;
          end
        end
        EMIT: begin
          if (slot_free) begin
            if (cells[0].valid) begin
              if (emit_gap) begin
                regions.region_start <= prev_end[SW-1:0];
                regions.region_size  <= cells[0].start - prev_end[SW-1:0] - SW'(1);
                regions.region_free  <= 1'b1;
                regions.last_region  <= 1'b0;
                gap_done             <= 1'b1;
              end else begin
                regions.region_start <= cells[0].start;
                regions.region_size  <= cells[0].size;
                regions.region_free  <= 1'b0;
                regions.last_region  <= !cells[1].valid && !head_trail_pass;
                prev_end             <= head_end;
                gap_done             <= 1'b0;
                if (!cells[1].valid && !head_trail_pass) begin
                  state <= IDLE;
                end
              end
            end else begin
              if (trail_pass) begin
                regions.region_start <= prev_end[SW-1:0];
                regions.region_size  <= total_sectors - prev_end[SW-1:0];
                regions.region_free  <= 1'b1;
                regions.last_region  <= 1'b1;
              end
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hdl/esgf_cell.sv]
module esgf_cell (
  input  logic                clk,
  input  logic                rst,
  input  esgf_pkg::cell_ctrl_t ctrl,
  input  esgf_pkg::extent_t   left,
  input  logic                left_greater,
  input  esgf_pkg::extent_t   right,
  output esgf_pkg::extent_t   held,
  output logic                greater
);

  esgf_pkg::extent_t held_next;

  // A cell sits after the new item when it is empty or its start is larger,
  // which keeps equal starts in insertion order.
  assign greater = !held.valid || (held.start > ctrl.start);

  always_comb begin
    held_next = held;
    if (ctrl.shift) begin
      held_next = right;
    end else if (ctrl.load && greater) begin
      if (left_greater) begin
        held_next = left;
      end else begin
        held_next.valid = 1'b1;
        held_next.start = ctrl.start;
        held_next.size  = ctrl.size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else begin
      held.valid <= held_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    held.start <= held_next.start;
    held.size  <= held_next.size;
  end

endmodule

[bench/extent_sort_and_gap_finder_tb.sv]
`timescale 1ns / 1ps

module extent_sort_and_gap_finder_tb;

  localparam int ITEM_GOAL = 450;
  localparam int CALM_FROM = 370;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SW = esgf_pkg::SECTOR_W;

  typedef struct {
    logic [SW-1:0] first_sector;
    logic [SW-1:0] sectors;
    logic          is_free;
    logic          is_last;
  } region_t;

  class region_scoreboard;
    logic [SW-1:0]              kept_starts[$];
    logic [SW-1:0]              kept_sizes[$];
    logic [SW-1:0]              total_sectors;
    logic [esgf_pkg::GAP_W-1:0] min_gap;
    region_t                    expected_regions[$];
    int                         errors;

    function new();
      total_sectors = '0;
      min_gap = esgf_pkg::GAP_RESET;
      errors = 0;
    endfunction

    function void write_register(logic [esgf_pkg::CFG_INDEX_W-1:0] index,
                                 logic [esgf_pkg::CFG_DATA_W-1:0] data);
      if (index == esgf_pkg::CFG_TOTAL_SECTORS) begin
        total_sectors = data;
      end else if (index == esgf_pkg::CFG_MIN_GAP) begin
        min_gap = data[esgf_pkg::GAP_W-1:0];
      end
    endfunction

    function void add_region(ref region_t run[$], input logic [SW-1:0] first_sector,
                             input logic [SW-1:0] sectors, input logic is_free);
      region_t r;
      r.first_sector = first_sector;
      r.sectors = sectors;
      r.is_free = is_free;
      r.is_last = 1'b0;
      run.push_back(r);
    endfunction

    // The store is kept in start order; an equal start goes after the ones
    // already present, which keeps the sort stable.
    function void note_item(logic action, logic [SW-1:0] entry_start,
                            logic [SW-1:0] entry_size, logic is_filesystem);
      int pos;
      logic [SW+1:0] prev_end;
      logic [SW+1:0] gap_span;
      region_t run[$];
      region_t r;
      if (action == esgf_pkg::ACTION_INSERT) begin
        if (is_filesystem && kept_starts.size() < esgf_pkg::MAX_EXTENTS) begin
          pos = kept_starts.size();
          for (int i = 0; i < kept_starts.size(); i++) begin
            if (kept_starts[i] > entry_start) begin
              pos = i;
              break;
            end
          end
          kept_starts.insert(pos, entry_start);
          kept_sizes.insert(pos, entry_size);
        end
        return;
      end
      prev_end = '0;
      for (int i = 0; i < kept_starts.size(); i++) begin
        if (prev_end + min_gap < {2'b00, kept_starts[i]}) begin
          gap_span = {2'b00, kept_starts[i]} - prev_end - 1;
          add_region(run, prev_end[SW-1:0], gap_span[SW-1:0], 1'b1);
        end
        add_region(run, kept_starts[i], kept_sizes[i], 1'b0);
        prev_end = {2'b00, kept_starts[i]} + {2'b00, kept_sizes[i]};
      end
      if (prev_end + min_gap < {2'b00, total_sectors}) begin
        gap_span = {2'b00, total_sectors} - prev_end;
        add_region(run, prev_end[SW-1:0], gap_span[SW-1:0], 1'b1);
      end
      if (run.size() > 0) begin
        r = run.pop_back();
        r.is_last = 1'b1;
        run.push_back(r);
      end
      foreach (run[i]) expected_regions.push_back(run[i]);
      kept_starts.delete();
      kept_sizes.delete();
    endfunction

    function void check_region(logic [SW-1:0] region_start,
                               logic [SW-1:0] region_size,
                               logic region_free, logic last_region);
      region_t exp;
      if (expected_regions.size() == 0) begin
        $error("Unexpected region: start %0h size %0h free %0b last %0b",
               region_start, region_size, region_free, last_region);
        errors++;
        return;
      end
      exp = expected_regions.pop_front();
      if (exp.first_sector !== region_start) begin
        $error("region_start: expected %0h, actual %0h", exp.first_sector, region_start);
        errors++;
      end
      if (exp.sectors !== region_size) begin
        $error("region_size: expected %0h, actual %0h", exp.sectors, region_size);
        errors++;
      end
      if (exp.is_free !== region_free) begin
        $error("region_free: expected %0b, actual %0b", exp.is_free, region_free);
        errors++;
      end
      if (exp.is_last !== last_region) begin
        $error("last_region: expected %0b, actual %0b", exp.is_last, last_region);
        errors++;
      end
    endfunction

    function int pending();
      return expected_regions.size();
    endfunction

    function int final_errors();
      if (expected_regions.size() != 0) begin
        $error("%0d expected regions never arrived", expected_regions.size());
        errors++;
      end
      return errors;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [esgf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [esgf_pkg::CFG_DATA_W-1:0] cfg_data;
  logic idle_on;
  logic hold_request;
  int items_sent;

  esgf_in_if items_if();
  esgf_out_if regions_if();

  region_scoreboard sb = new();

  extent_sort_and_gap_finder dut (
    .clk(clk),
    .rst(rst),
    .items(items_if),
    .regions(regions_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && items_if.valid && items_if.ready) begin
      sb.note_item(items_if.action, items_if.entry_start, items_if.entry_size,
                   items_if.is_filesystem);
    end
    if (!rst && regions_if.valid && regions_if.ready) begin
      sb.check_region(regions_if.region_start, regions_if.region_size,
                      regions_if.region_free, regions_if.last_region);
    end
  end

  initial begin
    regions_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        regions_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        regions_if.ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        regions_if.ready = 1'b1;
      end
    end
  end

  initial begin
    #(3_000_000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic action, input logic [SW-1:0] entry_start,
                           input logic [SW-1:0] entry_size, input logic is_filesystem);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      items_if.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    items_if.valid = 1'b1;
    items_if.action = action;
    items_if.entry_start = entry_start;
    items_if.entry_size = entry_size;
    items_if.is_filesystem = is_filesystem;
    do @(posedge clk); while (!items_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    int waited;
    waited = 0;
    items_if.valid = 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [esgf_pkg::CFG_INDEX_W-1:0] index,
                                input logic [esgf_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_register(index, data);
  endtask

  task automatic write_random_config();
    logic [SW-1:0] total;
    logic [esgf_pkg::GAP_W-1:0] gap;
    case ($urandom_range(0, 3))
      0: total = '0;
      1: total = '1;
      2: total = $urandom;
      default: total = $urandom_range(0, 200000);
    endcase
    case ($urandom_range(0, 3))
      0: gap = '0;
      1: gap = '1;
      2: gap = $urandom_range(0, 65535);
      default: gap = $urandom_range(0, 64);
    endcase
    if ($urandom_range(0, 3) != 0) write_register(esgf_pkg::CFG_TOTAL_SECTORS, total);
    if ($urandom_range(0, 3) != 0) write_register(esgf_pkg::CFG_MIN_GAP, {16'h0000, gap});
  endtask

  task automatic run_sequence();
    int n;
    int kind;
    logic [SW-1:0] span;
    logic [SW-1:0] prev_start;
    logic [SW-1:0] prev_size;
    logic [SW-1:0] entry_start;
    logic [SW-1:0] entry_size;
    logic noisy;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      n = $urandom_range(0, 6);
    end else if (kind < 9) begin
      n = $urandom_range(7, 15);
    end else begin
      n = $urandom_range(16, 20);
    end
    noisy = ($urandom_range(0, 9) == 0);
    span = ($urandom_range(0, 1) == 0) ? 32'd200000 : sb.total_sectors;
    prev_start = $urandom_range(0, 5000);
    prev_size = $urandom_range(0, 2000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 6))
        0: entry_start = $urandom;
        1: entry_start = prev_start;
        2: entry_start = prev_start + prev_size + sb.min_gap + $urandom_range(0, 2);
        3: entry_start = prev_start + prev_size + $urandom_range(0, 3000);
        default: entry_start = $urandom_range(0, span);
      endcase
      if ($urandom_range(0, 4) == 0) begin
        entry_size = $urandom;
      end else begin
        entry_size = $urandom_range(0, 20000);
      end
      send_item(esgf_pkg::ACTION_INSERT, entry_start, entry_size,
                noisy ? logic'($urandom_range(0, 1)) : logic'($urandom_range(0, 9) != 0));
      prev_start = entry_start;
      prev_size = entry_size;
    end
    send_item(esgf_pkg::ACTION_FINISH, $urandom, $urandom, logic'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [SW-1:0] s;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = esgf_pkg::CFG_TOTAL_SECTORS;
    cfg_data = '0;
    idle_on = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    items_if.valid = 1'b0;
    items_if.action = esgf_pkg::ACTION_INSERT;
    items_if.entry_start = '0;
    items_if.entry_size = '0;
    items_if.is_filesystem = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // An empty store with the reset settings emits nothing, and an insert
    // that is not a filesystem partition is ignored.
    send_item(esgf_pkg::ACTION_FINISH, '1, '1, 1'b1);
    send_item(esgf_pkg::ACTION_INSERT, '1, '1, 1'b0);
    send_item(esgf_pkg::ACTION_FINISH, '0, '0, 1'b0);
    wait_drain();

    write_register(esgf_pkg::CFG_TOTAL_SECTORS, '1);
    write_register(esgf_pkg::CFG_MIN_GAP, '0);
    send_item(esgf_pkg::ACTION_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(esgf_pkg::ACTION_INSERT, 32'd100, 32'd50, 1'b1);
    send_item(esgf_pkg::ACTION_INSERT, 32'd0, 32'd0, 1'b1);
    send_item(esgf_pkg::ACTION_INSERT, 32'd100, 32'd7, 1'b1);
    send_item(esgf_pkg::ACTION_INSERT, 32'd5000, 32'd10, 1'b1);
    send_item(esgf_pkg::ACTION_INSERT, 32'd7, 32'd3, 1'b0);
    send_item(esgf_pkg::ACTION_FINISH, '0, '0, 1'b0);
    wait_drain();

    // Seventeen inserts in falling start order overflow the store.
    write_register(esgf_pkg::CFG_MIN_GAP, 32'h0000_FFFF);
    write_register(esgf_pkg::CFG_TOTAL_SECTORS, 32'h0100_0000);
    for (int i = 0; i < esgf_pkg::MAX_EXTENTS + 1; i++) begin
      s = (esgf_pkg::MAX_EXTENTS - i) * 100000 + $urandom_range(0, 30000);
      send_item(esgf_pkg::ACTION_INSERT, s, $urandom_range(0, 50000), 1'b1);
    end
    send_item(esgf_pkg::ACTION_FINISH, '1, '0, 1'b1);
    wait_drain();

    // The receiver stalls long enough for the block to refuse input.
    idle_on = 1'b1;
    write_register(esgf_pkg::CFG_MIN_GAP, 32'd16);
    hold_request = 1'b1;
    for (int i = 0; i < 10; i++) send_item(esgf_pkg::ACTION_INSERT,
                                           $urandom_range(0, 200000),
                                           $urandom_range(0, 2000), 1'b1);
    send_item(esgf_pkg::ACTION_FINISH, '0, '0, 1'b0);
    for (int i = 0; i < 6; i++) send_item(esgf_pkg::ACTION_INSERT,
                                          $urandom_range(0, 200000),
                                          $urandom_range(0, 2000), 1'b1);
    send_item(esgf_pkg::ACTION_FINISH, '0, '0, 1'b0);

    while (items_sent < ITEM_GOAL) begin
      wait_drain();
      if ($urandom_range(0, 2) != 0) write_random_config();
      idle_on = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) run_sequence();
    end
    wait_drain();

    if (sb.final_errors() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
